>>> hdl/mtms_pkg.sv
package mtms_pkg;

	localparam int CHANNELS      = 8;
	localparam int HISTORY_DEPTH = 10;
	localparam int AVG_SHIFT     = 3;

	localparam int SAMPLE_W   = 12;
	localparam int CHAN_OUT_W = 3;
	localparam int MV_W       = 12;

	localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SLOT_W    = $clog2(HISTORY_DEPTH);
	localparam int MEM_DEPTH = CHANNELS * HISTORY_DEPTH;
	localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int SUM_W     = $clog2(HISTORY_DEPTH * (1 << SAMPLE_W));

	localparam int FULL_SCALE = 4095;
	localparam int MV_SCALE   = 3300;
	localparam int PROD_W     = 2 * SAMPLE_W;

endpackage

>>> hdl/mtms_in_if.sv
interface mtms_in_if
	import mtms_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] raw_sample;

	modport source (output valid, raw_sample, input ready);
	modport sink   (input valid, raw_sample, output ready);
endinterface

>>> hdl/mtms_out_if.sv
interface mtms_out_if
	import mtms_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CHAN_OUT_W-1:0] channel;
	logic [SAMPLE_W-1:0]   average;
	logic [MV_W-1:0]       millivolts;

	modport source (output valid, channel, average, millivolts, input ready);
	modport sink   (input valid, channel, average, millivolts, output ready);
endinterface

>>> hdl/multichannel_trimmed_mean_smoother.sv
// Each accepted item is written to the history RAM, then its HISTORY_DEPTH entries are read
//   through the registered history RAM read port, then trim, scale and divide steps follow.
// Items do not overlap: the next is taken only after the walk over the RAM and the divide step.
// A new item is taken while the previous result still waits on the output register.
// Reset (arst_n, async, active low) clears pointers, control and the per-entry
// valid bits; history entries never written read as zero.
module multichannel_trimmed_mean_smoother
	import mtms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	mtms_in_if.sink    samples,
	mtms_out_if.source results
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_WRITE = 7'b0000010,
		S_READ  = 7'b0000100,
		S_LAST  = 7'b0001000,
		S_CALC  = 7'b0010000,
		S_MUL   = 7'b0100000,
		S_DIV   = 7'b1000000
	} state_t;

	state_t state_q;

	// history store and its valid bits
	logic [SAMPLE_W-1:0]  mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] valid_q;

	logic [SLOT_W-1:0]   slot_ptr_q [CHANNELS];
	logic [CH_W-1:0]     chan_ptr_q;

	logic [CH_W-1:0]     ch_q;
	logic [ADDR_W-1:0]   base_q;
	logic [ADDR_W-1:0]   wr_addr_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [SLOT_W-1:0]   cnt_q;

	logic [SAMPLE_W-1:0] rdata_s1;
	logic                rvld_s1;
	logic                rd_s1;

	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] lo_q;
	logic [SAMPLE_W-1:0] hi_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic [PROD_W-1:0]   prod_q;

	logic                out_valid_q;
	logic [CHAN_OUT_W-1:0] out_ch_q;
	logic [SAMPLE_W-1:0] out_avg_q;
	logic [MV_W-1:0]     out_mv_q;

	logic                accept;
	logic [SLOT_W-1:0]   slot_cur;
	logic [SLOT_W-1:0]   slot_next;
	logic [CH_W-1:0]     chan_next;
	logic [ADDR_W-1:0]   base_cur;
	logic [ADDR_W-1:0]   rd_addr;
	logic                rd_en;
	logic [SAMPLE_W-1:0] rd_val;
	logic [SUM_W-1:0]    trimmed;
	logic [SUM_W-1:0]    shifted;
	logic [SAMPLE_W-1:0] mv_est;
	logic [SAMPLE_W:0]   mv_rem;
	logic [MV_W-1:0]     mv_val;
	logic                out_load;

	assign accept        = samples.valid && samples.ready;
	assign samples.ready = (state_q == S_IDLE);

	// slot and channel pointer advance
	always_comb begin
		slot_cur  = slot_ptr_q[chan_ptr_q];
		slot_next = (slot_cur == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_cur + 1'b1;
		chan_next = (chan_ptr_q == CH_W'(CHANNELS - 1)) ? '0 : chan_ptr_q + 1'b1;
		base_cur  = ADDR_W'(chan_ptr_q * HISTORY_DEPTH);
	end

	assign rd_en   = (state_q == S_READ);
	assign rd_addr = base_q + ADDR_W'(cnt_q);
	assign rd_val  = rvld_s1 ? rdata_s1 : '0;

	// trim and shift; saturation is applied where avg_q is registered
	always_comb begin
		trimmed = sum_q - SUM_W'(lo_q) - SUM_W'(hi_q);
		shifted = trimmed >> AVG_SHIFT;
	end

	// divide by 4095: estimate by 4096, then one correction step
	always_comb begin
		mv_est = prod_q[PROD_W-1:SAMPLE_W];
		mv_rem = {1'b0, prod_q[SAMPLE_W-1:0]} + {1'b0, mv_est};
		mv_val = (mv_rem >= (SAMPLE_W + 1)'(FULL_SCALE)) ? MV_W'(mv_est + 1'b1) : MV_W'(mv_est);
	end

	assign out_load = (state_q == S_DIV) && (!out_valid_q || results.ready);

	// memory port: one write, one registered read
	always_ff @(posedge clk) begin
		if (state_q == S_WRITE) begin
			mem[wr_addr_q] <= sample_q;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
			rvld_s1  <= valid_q[rd_addr];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			chan_ptr_q  <= '0;
			cnt_q       <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				slot_ptr_q[i] <= '0;
			end
		end else begin
			rd_s1 <= rd_en;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						slot_ptr_q[chan_ptr_q] <= slot_next;
						chan_ptr_q             <= chan_next;
						state_q                <= S_WRITE;
					end
				end
				S_WRITE: begin
					valid_q[wr_addr_q] <= 1'b1;
					cnt_q              <= '0;
					state_q            <= S_READ;
				end
				S_READ: begin
					if (cnt_q == SLOT_W'(HISTORY_DEPTH - 1)) begin
						state_q <= S_LAST;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_LAST:  state_q <= S_CALC;
				S_CALC:  state_q <= S_MUL;
				S_MUL:   state_q <= S_DIV;
				S_DIV: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q      <= chan_ptr_q;
			base_q    <= base_cur;
			wr_addr_q <= base_cur + ADDR_W'(slot_next);
			sample_q  <= samples.raw_sample;
			sum_q     <= '0;
			lo_q      <= '1;
			hi_q      <= '0;
		end
		if (rd_s1) begin
			sum_q <= sum_q + SUM_W'(rd_val);
			if (rd_val < lo_q) begin
				lo_q <= rd_val;
			end
			if (rd_val > hi_q) begin
				hi_q <= rd_val;
			end
		end
		if (state_q == S_CALC) begin
			avg_q <= (shifted > SUM_W'(FULL_SCALE)) ? SAMPLE_W'(FULL_SCALE)
				: SAMPLE_W'(shifted);
		end
		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(avg_q) * PROD_W'(MV_SCALE);
		end
		if (out_load) begin
			out_ch_q  <= CHAN_OUT_W'(ch_q);
			out_avg_q <= avg_q;
			out_mv_q  <= mv_val;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.channel    = out_ch_q;
	assign results.average    = out_avg_q;
	assign results.millivolts = out_mv_q;

endmodule
